FILE: hw/rtl/dratio_pkg.sv
// Package with the widths, register map and sequencer states of the density ratio unit.
`default_nettype none

package dratio_pkg;

   localparam int FRAC_BITS  = 16;

   localparam int SIZE_W     = 4;
   localparam int LSUM_W     = 20;
   localparam int CSUM_W     = 24;
   localparam int CFG_OFF_W  = 16;
   localparam int RATIO_W    = 32;
   localparam int MAX_W      = RATIO_W - 1;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int SUM_W      = LSUM_W + 1;
   localparam int MN_W       = 2 * SIZE_W;
   localparam int PAIR_W     = 2 * SIZE_W;
   localparam int OFF_W      = (FRAC_BITS > CFG_OFF_W) ? FRAC_BITS : CFG_OFF_W;
   localparam int OFF_UP     = (FRAC_BITS > CFG_OFF_W) ? FRAC_BITS - CFG_OFF_W : 0;
   localparam int OFF_DN     = (FRAC_BITS < CFG_OFF_W) ? CFG_OFF_W - FRAC_BITS : 0;
   localparam int OFFMN_W    = OFF_W + MN_W;
   localparam int DEN_W      = ((OFFMN_W > CSUM_W) ? OFFMN_W : CSUM_W) + 2;
   localparam int DMAG_W     = DEN_W - 1;
   localparam int DVR_W      = DMAG_W + PAIR_W;
   localparam int PROD_W     = SUM_W + MN_W;
   localparam int NUM_W      = PROD_W + FRAC_BITS;
   localparam int CNT_W      = $clog2(NUM_W + 1);

   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_OFFSET = 3'd0;
   localparam logic [CFG_OFF_W-1:0]  OFFSET_RESET    = 16'd655;

   localparam logic [RATIO_W-1:0] RATIO_POS_LIMIT = {1'b0, {(RATIO_W-1){1'b1}}};
   localparam logic [RATIO_W-1:0] RATIO_NEG_LIMIT = {1'b1, {(RATIO_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRODUCTS,
      ST_OFFSET,
      ST_DENOM,
      ST_SCALE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/density_ratio_with_running_max_unit.sv
// Density ratio unit: sequencer, bit-serial divider and running maximum of the ratio.
//
// Each input word on the req_ channel holds two group sizes and three
// fixed-point sums; the unit answers with one word on the rsp_ channel that
// carries the ratio in signed Q16.16, the running maximum and a flag for a
// clipped or undefined ratio. A word is taken when valid is high and stall
// is low on that channel.
// A word is handled in sequence: the products, offset, denominator and scale
// steps, then a restoring divider that yields one quotient bit per cycle,
// then a final step to saturate and update the maximum. The unit takes no
// new word until it has finished the last one; degenerate sizes and a zero
// divisor skip the divider.
// The result waits in an output register; while the receiver stalls, the
// next word is still accepted and worked on, and it waits at its final step
// until the output register is free.
// Reset clears the running maximum, empties the output register and sets the
// offset register to about 0.01. The offset is written over the csr_ port.
`default_nettype none

module density_ratio_with_running_max_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_first_of_set,
   input  wire logic [dratio_pkg::SIZE_W-1:0]       req_left_size,
   input  wire logic [dratio_pkg::SIZE_W-1:0]       req_right_size,
   input  wire logic [dratio_pkg::LSUM_W-1:0]       req_left_sum,
   input  wire logic [dratio_pkg::LSUM_W-1:0]       req_right_sum,
   input  wire logic [dratio_pkg::CSUM_W-1:0]       req_cross_sum,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [dratio_pkg::RATIO_W-1:0]    rsp_ratio_value,
   output logic [dratio_pkg::MAX_W-1:0]             rsp_max_so_far,
   output logic                                     rsp_saturated,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [dratio_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [dratio_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dratio_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                     csr_pready
);
   import dratio_pkg::*;

   state_type                state_ff, state_in;

   logic [CFG_OFF_W-1:0]     offset_ff, offset_in;

   logic                     first_ff, first_in;
   logic [SIZE_W-1:0]        m_ff, m_in;
   logic [SIZE_W-1:0]        n_ff, n_in;
   logic [LSUM_W-1:0]        l_ff, l_in;
   logic [LSUM_W-1:0]        r_ff, r_in;
   logic [CSUM_W-1:0]        c_ff, c_in;

   logic [SUM_W-1:0]         s_ff, s_in;
   logic [MN_W-1:0]          mn_ff, mn_in;
   logic [PAIR_W-1:0]        p_ff, p_in;
   logic [OFFMN_W-1:0]       offmn_ff, offmn_in;
   logic                     degen_ff, degen_in;
   logic                     neg_ff, neg_in;
   logic                     den_zero_ff, den_zero_in;
   logic [DMAG_W-1:0]        dmag_ff, dmag_in;

   logic [NUM_W-1:0]         numer_ff, numer_in;
   logic [DVR_W-1:0]         divisor_ff, divisor_in;
   logic [DVR_W-1:0]         rem_ff, rem_in;
   logic [RATIO_W-1:0]       quo_ff, quo_in;
   logic                     ovf_ff, ovf_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   logic [MAX_W-1:0]         max_ff, max_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RATIO_W-1:0]       rsp_ratio_ff, rsp_ratio_in;
   logic [MAX_W-1:0]         rsp_max_ff, rsp_max_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   logic [OFF_W-1:0]         off_frac;
   logic [DEN_W-1:0]         den_sum;
   logic [DVR_W:0]           trial;
   logic                     qbit;
   logic [RATIO_W-1:0]       fval;
   logic                     fsat;
   logic [MAX_W-1:0]         max_base;
   logic                     out_free;
   logic                     csr_write;

   function automatic logic [PAIR_W-1:0] pair_count(input logic [SIZE_W-1:0] k);
      logic [PAIR_W-1:0] prod;
      prod = PAIR_W'(k) * PAIR_W'(k - SIZE_W'(1));
      return prod >> 1;
   endfunction

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_ADDR_OFFSET[CSR_ADDR_W-1]) ?
                       CSR_DATA_W'(offset_ff) : '0;

   assign off_frac = (OFF_W'(offset_ff) << OFF_UP) >> OFF_DN;
   assign den_sum  = DEN_W'(c_ff) - DEN_W'(s_ff) + DEN_W'(offmn_ff);
   assign trial    = {rem_ff, numer_ff[NUM_W-1]} - {1'b0, divisor_ff};
   assign qbit     = !trial[DVR_W];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign max_base = first_ff ? '0 : max_ff;

   always_comb begin
      fval = '0;
      fsat = 1'b1;
      if (degen_ff) begin
         fval = '0;
      end else if (den_zero_ff) begin
         fval = (s_ff != '0) ? RATIO_POS_LIMIT : '0;
      end else if (ovf_ff) begin
         fval = neg_ff ? RATIO_NEG_LIMIT : RATIO_POS_LIMIT;
      end else if (!neg_ff) begin
         fval = quo_ff[RATIO_W-1] ? RATIO_POS_LIMIT : quo_ff;
         fsat = quo_ff[RATIO_W-1];
      end else if (quo_ff[RATIO_W-1] && (quo_ff[RATIO_W-2:0] != '0)) begin
         fval = RATIO_NEG_LIMIT;
      end else begin
         fval = '0 - quo_ff;
         fsat = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      offset_in    = offset_ff;
      first_in     = first_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      mn_in        = mn_ff;
      p_in         = p_ff;
      offmn_in     = offmn_ff;
      degen_in     = degen_ff;
      neg_in       = neg_ff;
      den_zero_in  = den_zero_ff;
      dmag_in      = dmag_ff;
      numer_in     = numer_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ratio_in = rsp_ratio_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (csr_write && (csr_paddr[CSR_ADDR_W-1] == CSR_ADDR_OFFSET[CSR_ADDR_W-1])) begin
         offset_in = csr_pwdata[CFG_OFF_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               first_in = req_first_of_set;
               m_in     = req_left_size;
               n_in     = req_right_size;
               l_in     = req_left_sum;
               r_in     = req_right_sum;
               c_in     = req_cross_sum;
               state_in = ST_PRODUCTS;
            end
         end
         ST_PRODUCTS: begin
            s_in     = SUM_W'(l_ff) + SUM_W'(r_ff);
            mn_in    = MN_W'(m_ff) * MN_W'(n_ff);
            p_in     = pair_count(m_ff) + pair_count(n_ff);
            state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            offmn_in = OFFMN_W'(off_frac) * OFFMN_W'(mn_ff);
            numer_in = {PROD_W'(s_ff) * PROD_W'(mn_ff), {FRAC_BITS{1'b0}}};
            degen_in = (mn_ff == '0) || (p_ff == '0);
            state_in = ST_DENOM;
         end
         ST_DENOM: begin
            neg_in      = den_sum[DEN_W-1];
            den_zero_in = (den_sum == '0);
            dmag_in     = den_sum[DEN_W-1] ? DMAG_W'('0 - den_sum) : den_sum[DMAG_W-1:0];
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            divisor_in = DVR_W'(dmag_ff) * DVR_W'(p_ff);
            rem_in     = '0;
            quo_in     = '0;
            ovf_in     = 1'b0;
            cnt_in     = CNT_W'(NUM_W);
            state_in   = (degen_ff || den_zero_ff) ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in   = qbit ? trial[DVR_W-1:0] : {rem_ff[DVR_W-2:0], numer_ff[NUM_W-1]};
            numer_in = numer_ff << 1;
            quo_in   = {quo_ff[RATIO_W-2:0], qbit};
            ovf_in   = ovf_ff || quo_ff[RATIO_W-1];
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               if (!fval[RATIO_W-1] && (fval[MAX_W-1:0] > max_base)) begin
                  max_in = fval[MAX_W-1:0];
               end else begin
                  max_in = max_base;
               end
               rsp_valid_in = 1'b1;
               rsp_ratio_in = fval;
               rsp_max_in   = max_in;
               rsp_sat_in   = fsat;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         offset_ff    <= OFFSET_RESET;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      m_ff         <= m_in;
      n_ff         <= n_in;
      l_ff         <= l_in;
      r_ff         <= r_in;
      c_ff         <= c_in;
      s_ff         <= s_in;
      mn_ff        <= mn_in;
      p_ff         <= p_in;
      offmn_ff     <= offmn_in;
      degen_ff     <= degen_in;
      neg_ff       <= neg_in;
      den_zero_ff  <= den_zero_in;
      dmag_ff      <= dmag_in;
      numer_ff     <= numer_in;
      divisor_ff   <= divisor_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      ovf_ff       <= ovf_in;
      cnt_ff       <= cnt_in;
      rsp_ratio_ff <= rsp_ratio_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ratio_value = $signed(rsp_ratio_ff);
   assign rsp_max_so_far  = rsp_max_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

`default_nettype wire

FILE: dv/density_ratio_with_running_max_unit_test.sv
// Self-checking testbench for the density ratio unit with its running maximum of the ratio.
`timescale 1ns / 1ps

module density_ratio_with_running_max_unit_test;
   import dratio_pkg::*;

   typedef struct packed {
      logic                first_of_set;
      logic [SIZE_W-1:0]   left_size;
      logic [SIZE_W-1:0]   right_size;
      logic [LSUM_W-1:0]   left_sum;
      logic [LSUM_W-1:0]   right_sum;
      logic [CSUM_W-1:0]   cross_sum;
   } ratio_word_type;

   typedef struct packed {
      logic [RATIO_W-1:0]  ratio_value;
      logic [MAX_W-1:0]    max_so_far;
      logic                saturated;
   } ratio_result_type;

   typedef struct packed {
      logic                load_offset;
      logic [CFG_OFF_W-1:0] offset;
      ratio_word_type      word;
      logic                typed;
      ratio_result_type    want;
   } directed_row_type;

   localparam int DIRECTED_COUNT  = 22;
   localparam int PHASE_COUNT     = 6;
   localparam int PHASE_WORDS     = 140;
   localparam int PRESSURE_AFTER  = 230;
   localparam int PRESSURE_CYCLES = 900;
   localparam int TAIL_CYCLES     = 60;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_first_of_set = 1'b0;
   logic [SIZE_W-1:0]       req_left_size = '0;
   logic [SIZE_W-1:0]       req_right_size = '0;
   logic [LSUM_W-1:0]       req_left_sum = '0;
   logic [LSUM_W-1:0]       req_right_sum = '0;
   logic [CSUM_W-1:0]       req_cross_sum = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [RATIO_W-1:0] rsp_ratio_value;
   logic [MAX_W-1:0]        rsp_max_so_far;
   logic                    rsp_saturated;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   ratio_result_type        expected_ratios [$];
   logic [CFG_OFF_W-1:0]    model_offset = OFFSET_RESET;
   logic [MAX_W-1:0]        model_peak = '0;
   int unsigned             errors = 0;
   int unsigned             words_sent = 0;
   int unsigned             results_seen = 0;
   int unsigned             saturated_seen = 0;
   int unsigned             offsets_used = 1;

   // Zero-divisor, saturation and degenerate-size rows carry their result inline.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      {1'b0, 16'h0000, 1'b1, 4'd0,  4'd5,  20'h12345, 20'h12345, 24'h123456,
       1'b1, 32'h0000_0000, 31'h0000_0000, 1'b1},
      {1'b0, 16'h0000, 1'b0, 4'd1,  4'd1,  20'hFFFFF, 20'hFFFFF, 24'hFFFFFF,
       1'b1, 32'h0000_0000, 31'h0000_0000, 1'b1},
      {1'b0, 16'h0000, 1'b0, 4'd5,  4'd0,  20'h00000, 20'h00000, 24'h000000,
       1'b1, 32'h0000_0000, 31'h0000_0000, 1'b1},
      {1'b0, 16'h0000, 1'b0, 4'd0,  4'd0,  20'hABCDE, 20'h54321, 24'h0F0F0F,
       1'b1, 32'h0000_0000, 31'h0000_0000, 1'b1},
      {1'b0, 16'h0000, 1'b0, 4'd2,  4'd2,  20'h10000, 20'h10000, 24'h01F5C4,
       1'b1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1},
      {1'b0, 16'h0000, 1'b0, 4'd2,  4'd2,  20'h10000, 20'h10000, 24'h040000,
       1'b0, 64'd0},
      {1'b0, 16'h0000, 1'b0, 4'd15, 4'd15, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF,
       1'b0, 64'd0},
      {1'b0, 16'h0000, 1'b0, 4'd12, 4'd12, 20'hC0000, 20'hC0000, 24'h900000,
       1'b0, 64'd0},
      {1'b0, 16'h0000, 1'b0, 4'd1,  4'd2,  20'h08000, 20'h04000, 24'h030000,
       1'b0, 64'd0},
      {1'b0, 16'h0000, 1'b1, 4'd3,  4'd7,  20'h00000, 20'h00000, 24'h000001,
       1'b0, 64'd0},
      {1'b0, 16'h0000, 1'b0, 4'd12, 4'd2,  20'h00000, 20'h00000, 24'h000000,
       1'b0, 64'd0},
      {1'b1, 16'h0000, 1'b1, 4'd2,  4'd2,  20'h00000, 20'h00000, 24'h000000,
       1'b1, 32'h0000_0000, 31'h0000_0000, 1'b1},
      {1'b0, 16'h0000, 1'b0, 4'd2,  4'd2,  20'h10000, 20'h00000, 24'h010000,
       1'b1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1},
      {1'b0, 16'h0000, 1'b1, 4'd2,  4'd2,  20'hFFFFF, 20'hFFFFF, 24'h000000,
       1'b1, 32'hFFFE_0000, 31'h0000_0000, 1'b0},
      {1'b0, 16'h0000, 1'b0, 4'd2,  4'd2,  20'h10000, 20'h10000, 24'h01FFFF,
       1'b1, 32'h8000_0000, 31'h0000_0000, 1'b1},
      {1'b0, 16'h0000, 1'b1, 4'd2,  4'd2,  20'h04000, 20'h00000, 24'h003FFF,
       1'b1, 32'h8000_0000, 31'h0000_0000, 1'b0},
      {1'b0, 16'h0000, 1'b0, 4'd2,  4'd2,  20'h10000, 20'h10000, 24'h020001,
       1'b1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1},
      {1'b0, 16'h0000, 1'b0, 4'd4,  4'd4,  20'h20000, 20'h30000, 24'h200000,
       1'b0, 64'd0},
      {1'b1, 16'hFFFF, 1'b1, 4'd15, 4'd15, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF,
       1'b0, 64'd0},
      {1'b0, 16'h0000, 1'b0, 4'd2,  4'd3,  20'h00001, 20'h00000, 24'h000000,
       1'b0, 64'd0},
      {1'b0, 16'h0000, 1'b0, 4'd1,  4'd2,  20'hFFFFF, 20'hFFFFF, 24'h000000,
       1'b0, 64'd0},
      {1'b0, 16'h0000, 1'b1, 4'd12, 4'd12, 20'h00001, 20'h00000, 24'h900000,
       1'b0, 64'd0}
   };

   density_ratio_with_running_max_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_of_set (req_first_of_set),
      .req_left_size    (req_left_size),
      .req_right_size   (req_right_size),
      .req_left_sum     (req_left_sum),
      .req_right_sum    (req_right_sum),
      .req_cross_sum    (req_cross_sum),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ratio_value  (rsp_ratio_value),
      .rsp_max_so_far   (rsp_max_so_far),
      .rsp_saturated    (rsp_saturated),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic longint unsigned scaled_offset(input logic [CFG_OFF_W-1:0] reg_value);
      if (FRAC_BITS >= CFG_OFF_W) begin
         return 64'(reg_value) << (FRAC_BITS - CFG_OFF_W);
      end
      return 64'(reg_value) >> (CFG_OFF_W - FRAC_BITS);
   endfunction

   function automatic ratio_result_type predict_ratio(input ratio_word_type w,
                                                      input logic [CFG_OFF_W-1:0] offset_reg,
                                                      inout logic [MAX_W-1:0] peak);
      longint unsigned  m, n, s, mn, pairs, dmag, quo;
      longint signed    den;
      ratio_result_type r;
      m     = 64'(w.left_size);
      n     = 64'(w.right_size);
      s     = 64'(w.left_sum) + 64'(w.right_sum);
      mn    = m * n;
      pairs = ((m == 64'd0) ? 64'd0 : m * (m - 64'd1) / 64'd2)
            + ((n == 64'd0) ? 64'd0 : n * (n - 64'd1) / 64'd2);
      r     = '0;
      if (w.first_of_set) begin
         peak = '0;
      end
      if (mn == 64'd0 || pairs == 64'd0) begin
         r.saturated = 1'b1;
      end else begin
         den = $signed(64'(w.cross_sum)) - $signed(s) + $signed(scaled_offset(offset_reg) * mn);
         if (den == 64'sd0) begin
            r.ratio_value = (s != 64'd0) ? RATIO_POS_LIMIT : '0;
            r.saturated   = 1'b1;
         end else begin
            dmag = (den < 64'sd0) ? 64'(-den) : 64'(den);
            quo  = ((s * mn) << FRAC_BITS) / (dmag * pairs);
            if (den > 64'sd0 && quo > 64'h7FFF_FFFF) begin
               r.ratio_value = RATIO_POS_LIMIT;
               r.saturated   = 1'b1;
            end else if (den < 64'sd0 && quo > 64'h8000_0000) begin
               r.ratio_value = RATIO_NEG_LIMIT;
               r.saturated   = 1'b1;
            end else if (den > 64'sd0) begin
               r.ratio_value = quo[RATIO_W-1:0];
            end else begin
               r.ratio_value = -quo[RATIO_W-1:0];
            end
         end
      end
      if (!r.ratio_value[RATIO_W-1] && r.ratio_value[MAX_W-1:0] > peak) begin
         peak = r.ratio_value[MAX_W-1:0];
      end
      r.max_so_far = peak;
      return r;
   endfunction

   // Most words are well formed; a share sits on or next to a zero divisor.
   function automatic ratio_word_type random_word(input logic [CFG_OFF_W-1:0] offset_reg);
      ratio_word_type  w;
      int unsigned     kind;
      longint signed   target;
      w.first_of_set = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
         w.left_size  = SIZE_W'($urandom_range(0, 15));
         w.right_size = SIZE_W'($urandom_range(0, 15));
      end else begin
         w.left_size  = SIZE_W'($urandom_range(2, 12));
         w.right_size = SIZE_W'($urandom_range(2, 12));
      end
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         w.left_sum  = LSUM_W'($urandom);
         w.right_sum = LSUM_W'($urandom);
         w.cross_sum = CSUM_W'($urandom);
      end else if (kind < 6) begin
         w.left_sum  = LSUM_W'($urandom_range(0, 786432));
         w.right_sum = LSUM_W'($urandom_range(0, 786432));
         w.cross_sum = CSUM_W'($urandom_range(0, 9437184));
      end else if (kind < 7) begin
         w.left_sum  = LSUM_W'($urandom_range(0, 255));
         w.right_sum = LSUM_W'($urandom_range(0, 255));
         w.cross_sum = CSUM_W'($urandom_range(0, 1023));
      end else begin
         w.left_sum  = LSUM_W'($urandom_range(0, 786432));
         w.right_sum = LSUM_W'($urandom_range(0, 786432));
         target = longint'(w.left_sum) + longint'(w.right_sum)
                - longint'(scaled_offset(offset_reg) * (64'(w.left_size) * 64'(w.right_size)))
                + longint'($urandom_range(0, 4)) - 64'sd2;
         if (target >= 64'sd0 && target < (64'sd1 <<< CSUM_W)) begin
            w.cross_sum = CSUM_W'(target);
         end else begin
            w.cross_sum = CSUM_W'($urandom_range(0, 9437184));
         end
      end
      return w;
   endfunction

   task automatic send_word(input ratio_word_type w, input logic typed,
                            input ratio_result_type want);
      ratio_result_type predicted;
      req_valid        <= 1'b1;
      req_first_of_set <= w.first_of_set;
      req_left_size    <= w.left_size;
      req_right_size   <= w.right_size;
      req_left_sum     <= w.left_sum;
      req_right_sum    <= w.right_sum;
      req_cross_sum    <= w.cross_sum;
      do @(posedge clock); while (req_stall);
      predicted = predict_ratio(w, model_offset, model_peak);
      expected_ratios.push_back(typed ? want : predicted);
      words_sent++;
   endtask

   task automatic idle_sender();
      int unsigned pick, gap;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         gap = 0;
      end else if (pick < 90) begin
         gap = $urandom_range(1, 4);
      end else begin
         gap = $urandom_range(5, 80);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_ratios.size() != 0) @(posedge clock);
   endtask

   // The offset is written and then read back while the unit is idle.
   task automatic set_density_offset(input logic [CFG_OFF_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_OFFSET;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      model_offset = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         $error("density_offset: expected %h, got %h", CSR_DATA_W'(value), csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      offsets_used++;
   endtask

   always @(posedge clock) begin : check_results
      ratio_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_saturated === 1'b1) begin
            saturated_seen++;
         end
         if (expected_ratios.size() == 0) begin
            $error("result word arrived with no word outstanding");
            errors++;
         end else begin
            want = expected_ratios.pop_front();
            if (rsp_ratio_value !== want.ratio_value) begin
               $error("ratio_value: expected %h, got %h", want.ratio_value, rsp_ratio_value);
               errors++;
            end
            if (rsp_max_so_far !== want.max_so_far) begin
               $error("max_so_far: expected %h, got %h", want.max_so_far, rsp_max_so_far);
               errors++;
            end
            if (rsp_saturated !== want.saturated) begin
               $error("saturated: expected %b, got %b", want.saturated, rsp_saturated);
               errors++;
            end
         end
      end
   end

   // The receiver stalls at random and, once, for long enough to back the unit up.
   initial begin : receiver
      int unsigned run_len, hold_len, pick;
      bit          pressure_done;
      pressure_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end
         run_len = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 300) : $urandom_range(1, 10);
         rsp_stall <= 1'b0;
         repeat (run_len) @(posedge clock);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            hold_len = 0;
         end else if (pick < 85) begin
            hold_len = $urandom_range(1, 6);
         end else begin
            hold_len = $urandom_range(7, 80);
         end
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [CFG_OFF_W-1:0] phase_offset;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].load_offset) begin
            drain_results();
            set_density_offset(directed_rows[i].offset);
         end
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
         idle_sender();
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: phase_offset = 16'h0000;
            1: phase_offset = 16'hFFFF;
            3: phase_offset = 16'h0001;
            5: phase_offset = OFFSET_RESET;
            default: phase_offset = CFG_OFF_W'($urandom);
         endcase
         drain_results();
         set_density_offset(phase_offset);
         repeat (PHASE_WORDS) begin
            send_word(random_word(model_offset), 1'b0, '0);
            idle_sender();
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d words and checked %0d results, %0d of them saturated.",
               words_sent, results_seen, saturated_seen);
      $display("The density offset took %0d settings, including both extremes.", offsets_used);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("Timed out with %0d results still outstanding.", expected_ratios.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
